// ----- rtl/core/sfpp_pkg.sv -----
// Package with the types and constants shared by the framed packet parser.
package sfpp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'h55;
  localparam logic [7:0] SYNC_SECOND  = 8'hAA;
  localparam int         HEADER_BYTES = 4;
  localparam int         OUT_WORDS    = 6;
  localparam int         POS_W        = 4;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      word_t;
  typedef word_t [OUT_WORDS-1:0] word_vec_t;

  // Outcome of one accepted byte, passed from the framer to the output stage.
  typedef struct packed {
    logic      emit;
    word_vec_t words;
  } result_t;

endpackage

// ----- rtl/core/sfpp_if.sv -----
// Interfaces for the byte input channel and the packet result channel.
interface sfpp_byte_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface sfpp_words_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   word0;
  logic signed [15:0]   word1;
  logic signed [15:0]   word2;
  logic signed [15:0]   word3;
  logic signed [15:0]   word4;
  logic signed [15:0]   word5;

  modport source (output valid, output word0, output word1, output word2,
                  output word3, output word4, output word5, input ready);
  modport sink   (input valid, input word0, input word1, input word2,
                  input word3, input word4, input word5, output ready);
endinterface

// ----- rtl/core/sfpp_framer.sv -----
// Frame tracker: sync hunt, running checksum and payload word store.
module sfpp_framer #(
  parameter int PAYLOAD_WORDS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sfpp_pkg::byte_t   data_byte,
  output sfpp_pkg::result_t res
);

  localparam int FRAME_BYTES = sfpp_pkg::HEADER_BYTES + 2 * PAYLOAD_WORDS;
  localparam sfpp_pkg::pos_t LAST_POS = sfpp_pkg::POS_W'(FRAME_BYTES - 1);
  localparam sfpp_pkg::pos_t FIRST_PAYLOAD = sfpp_pkg::POS_W'(sfpp_pkg::HEADER_BYTES);

  sfpp_pkg::pos_t      pos;
  sfpp_pkg::pos_t      pos_next;
  sfpp_pkg::byte_t     sum;
  sfpp_pkg::byte_t     sum_next;
  sfpp_pkg::byte_t     sum_add;
  sfpp_pkg::pos_t      pos_off;
  logic [2:0]          slot;
  logic                in_payload;
  logic                frame_ok;
  sfpp_pkg::word_vec_t out_words;
  sfpp_pkg::word_t     store      [PAYLOAD_WORDS];
  sfpp_pkg::word_t     store_next [PAYLOAD_WORDS];

  assign sum_add    = sum + data_byte;
  assign in_payload = (pos >= FIRST_PAYLOAD);
  assign pos_off    = pos - FIRST_PAYLOAD;
  assign slot       = pos_off[3:1];
  assign res        = '{emit: frame_ok, words: out_words};

  always_comb begin
    pos_next = pos;
    sum_next = sum_add;
    frame_ok = 1'b0;
    case (pos)
      sfpp_pkg::POS_W'(0): begin
        if (data_byte == sfpp_pkg::SYNC_FIRST) begin
          pos_next = sfpp_pkg::POS_W'(1);
          sum_next = sfpp_pkg::SYNC_FIRST;
        end
      end
      sfpp_pkg::POS_W'(1): begin
        pos_next = (data_byte == sfpp_pkg::SYNC_SECOND) ? sfpp_pkg::POS_W'(2)
                                                        : sfpp_pkg::POS_W'(0);
      end
      default: begin
        if (pos == LAST_POS) begin
          pos_next = sfpp_pkg::POS_W'(0);
          frame_ok = (sum_add == 8'h00);
        end else begin
          pos_next = pos + sfpp_pkg::POS_W'(1);
        end
      end
    endcase
  end

  // The final byte of a frame is merged here so the result can leave at once.
  always_comb begin
    for (int k = 0; k < PAYLOAD_WORDS; k++) begin
      store_next[k] = store[k];
      if (in_payload && slot == 3'(k)) begin
        if (pos[0]) begin
          store_next[k] = {data_byte, store[k][7:0]};
        end else begin
          store_next[k] = {store[k][15:8], data_byte};
        end
      end
    end
    for (int k = 0; k < sfpp_pkg::OUT_WORDS; k++) begin
      if (k < PAYLOAD_WORDS) begin
        out_words[k] = store_next[k];
      end else begin
        out_words[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else if (take) begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < PAYLOAD_WORDS; k++) begin
        store[k] <= store_next[k];
      end
    end
  end

endmodule

// ----- rtl/core/sfpp_out_reg.sv -----
// Result register that drives the packet channel and gates input acceptance.
module sfpp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  sfpp_pkg::result_t    res,
  output logic                 in_ready,
  sfpp_words_if.source         out
);

  logic                valid;
  sfpp_pkg::word_vec_t words;

  // A new byte is taken whenever the held packet is empty or leaving now.
  assign in_ready = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take && res.emit) begin
      valid <= 1'b1;
    end else if (out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      words <= res.words;
    end
  end

  assign out.valid = valid;
  assign out.word0 = $signed(words[0]);
  assign out.word1 = $signed(words[1]);
  assign out.word2 = $signed(words[2]);
  assign out.word3 = $signed(words[3]);
  assign out.word4 = $signed(words[4]);
  assign out.word5 = $signed(words[5]);

endmodule

// ----- rtl/core/sync_framed_packet_parser.sv -----
// Top level of the sync-framed packet parser with an additive checksum.
//
// The in channel carries one received byte per transfer. The parser hunts for
// the sync pair 0x55 0xAA, counts two further header bytes, then gathers
// 2*PAYLOAD_WORDS payload bytes into 16-bit words, low byte first. Every byte
// adds to an 8-bit running sum that the first sync byte restarts at 0x55.
// When the last byte of a frame leaves the sum at zero, the words go out as one
// transfer on the out channel; words beyond PAYLOAD_WORDS read as zero.
// A byte is taken when in is valid and ready; the frame state updates in the
// same cycle, and a packet appears on out in the cycle after its final byte.
// Throughput is one byte per cycle unless a waiting packet stalls on out.
// Synchronous reset returns the parser to hunting with a zero sum and drops
// any packet waiting in the result register.
// While a packet waits and out is stalled, in stops taking bytes; a byte is
// still taken in the cycle the waiting packet is transferred.
module sync_framed_packet_parser #(
  parameter int PAYLOAD_WORDS = 6
) (
  input  logic        clk,
  input  logic        rst,
  sfpp_byte_if.sink   in,
  sfpp_words_if.source out
);

  logic              in_ready;
  logic              take;
  sfpp_pkg::result_t res;

  assign in.ready = in_ready;
  assign take     = in.valid && in_ready;

  sfpp_framer #(
    .PAYLOAD_WORDS (PAYLOAD_WORDS)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (in.data_byte),
    .res       (res)
  );

  sfpp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .res      (res),
    .in_ready (in_ready),
    .out      (out)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the sync-framed packet parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW           = 6;
  localparam int FRAME_LEN    = sfpp_pkg::HEADER_BYTES + 2 * PW;
  localparam int RANDOM_BYTES = 950;
  localparam int DIR_LEN      = 37;
  localparam int GOOD_END     = 20;  // last byte of the frame that passes its checksum
  localparam int BAD_PAY_LO   = 25;  // all but the last payload byte of the failing frame go to the predictor
  localparam int BAD_PAY_HI   = 35;
  localparam int HOLD_CYCLES  = 150;

  // Payload of the passing frame, word5 first.
  localparam sfpp_pkg::word_vec_t GOOD_WORDS = {16'h0001, 16'hAA55, 16'hFFFF,
                                                16'h0000, 16'h7FFF, 16'h8000};

  typedef struct packed {
    sfpp_pkg::byte_t     b;
    logic                typed;
    logic                emit;
    sfpp_pkg::word_vec_t words;
  } stim_t;

  // Hunting noise, a bad second byte that is itself 0x55, a stray 0xAA, then
  // a frame whose sum is zero and a frame whose sum is one.
  sfpp_pkg::byte_t dir_bytes [DIR_LEN] = '{
    8'h00, 8'hFF, sfpp_pkg::SYNC_FIRST, 8'h55, 8'hAA,
    sfpp_pkg::SYNC_FIRST, sfpp_pkg::SYNC_SECOND, 8'h00, 8'h05,
    8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h00,
    sfpp_pkg::SYNC_FIRST, sfpp_pkg::SYNC_SECOND, 8'h00, 8'h06,
    8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h00
  };

  logic clk;
  logic rst;

  sfpp_byte_if  byte_ch ();
  sfpp_words_if pkt_ch ();

  sync_framed_packet_parser #(.PAYLOAD_WORDS(PW)) DUT (
    .clk (clk),
    .rst (rst),
    .in  (byte_ch),
    .out (pkt_ch)
  );

  stim_t               stim [$];
  sfpp_pkg::word_vec_t pkt_q [$];
  int                  acc_idx = 0;
  int                  errors = 0;
  bit                  sending_done = 0;
  wire                 calm = (acc_idx >= 500) && (acc_idx < 700);

  // Predictor state.
  sfpp_pkg::pos_t  frame_pos = '0;
  sfpp_pkg::byte_t chk_sum = '0;
  sfpp_pkg::word_t payload_words [sfpp_pkg::OUT_WORDS];

  function automatic bit parse_byte(input sfpp_pkg::byte_t b,
                                    output sfpp_pkg::word_vec_t pkt);
    int w;
    int k;
    pkt = '0;
    chk_sum = chk_sum + b;
    if (frame_pos == 0) begin
      if (b == sfpp_pkg::SYNC_FIRST) begin
        chk_sum = sfpp_pkg::SYNC_FIRST;
        frame_pos = sfpp_pkg::pos_t'(1);
      end
      return 0;
    end
    if (frame_pos == 1) begin
      frame_pos = (b == sfpp_pkg::SYNC_SECOND) ? sfpp_pkg::pos_t'(2) : sfpp_pkg::pos_t'(0);
      return 0;
    end
    if (frame_pos >= sfpp_pkg::HEADER_BYTES) begin
      w = (int'(frame_pos) - sfpp_pkg::HEADER_BYTES) >> 1;
      if (frame_pos[0]) payload_words[w][15:8] = b;
      else payload_words[w][7:0] = b;
    end
    if (int'(frame_pos) == FRAME_LEN - 1) begin
      frame_pos = '0;
      if (chk_sum == 0) begin
        for (k = 0; k < PW; k++) pkt[k] = payload_words[k];
        return 1;
      end
      return 0;
    end
    frame_pos = frame_pos + sfpp_pkg::pos_t'(1);
    return 0;
  endfunction

  task automatic add_byte(input sfpp_pkg::byte_t b);
    stim_t row;
    row = '0;
    row.b = b;
    stim.push_back(row);
  endtask

  task automatic build_stimulus();
    stim_t           row;
    sfpp_pkg::byte_t frame_buf [FRAME_LEN];
    sfpp_pkg::byte_t s;
    int              i;
    int              j;
    int              pick;
    int              n;
    for (i = 0; i < DIR_LEN; i++) begin
      row = '0;
      row.b = dir_bytes[i];
      row.typed = !(i >= BAD_PAY_LO && i <= BAD_PAY_HI);
      row.emit = (i == GOOD_END);
      if (row.emit) row.words = GOOD_WORDS;
      stim.push_back(row);
    end
    while (stim.size() < DIR_LEN + RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Whole frame; most close with a byte that brings the sum to zero.
        frame_buf[0] = sfpp_pkg::SYNC_FIRST;
        frame_buf[1] = sfpp_pkg::SYNC_SECOND;
        s = sfpp_pkg::SYNC_FIRST + sfpp_pkg::SYNC_SECOND;
        for (j = 2; j < FRAME_LEN - 1; j++) begin
          frame_buf[j] = sfpp_pkg::byte_t'($urandom);
          s = s + frame_buf[j];
        end
        frame_buf[FRAME_LEN-1] = ($urandom_range(3) != 0) ? sfpp_pkg::byte_t'(-s)
                                                          : sfpp_pkg::byte_t'($urandom);
        for (j = 0; j < FRAME_LEN; j++) add_byte(frame_buf[j]);
      end else if (pick < 80) begin
        add_byte(sfpp_pkg::SYNC_FIRST);
        add_byte($urandom_range(1) ? 8'h55 : sfpp_pkg::byte_t'($urandom));
      end else if (pick < 90) begin
        // Cut-short frame: the bytes that follow it, even a sync pair, are taken as frame data.
        add_byte(sfpp_pkg::SYNC_FIRST);
        add_byte(sfpp_pkg::SYNC_SECOND);
        n = $urandom_range(13);
        for (j = 0; j < n; j++) add_byte(sfpp_pkg::byte_t'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) add_byte(sfpp_pkg::byte_t'($urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : sender
    int i;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    build_stimulus();
    do @(posedge clk); while (rst);
    for (i = 0; i < stim.size(); i++) begin
      while (!calm && $urandom_range(99) < 9) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      byte_ch.valid <= 1'b1;
      byte_ch.data_byte <= stim[i].b;
      do @(posedge clk); while (!byte_ch.ready);
    end
    byte_ch.valid <= 1'b0;
    sending_done = 1;
  end

  // The receiver stalls once for a long stretch so that a waiting packet
  // backs up into the byte channel.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    pkt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pkt_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held && acc_idx >= 300) begin
        held = 1;
        hold_left = HOLD_CYCLES;
        pkt_ch.ready <= 1'b0;
      end else begin
        pkt_ch.ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  sfpp_pkg::word_vec_t seen_pkt;
  sfpp_pkg::word_vec_t want_pkt;
  sfpp_pkg::word_vec_t pred_pkt;
  bit                  pred_emit;

  always @(posedge clk) begin
    if (!rst && pkt_ch.valid && pkt_ch.ready) begin
      seen_pkt = {pkt_ch.word5, pkt_ch.word4, pkt_ch.word3,
                  pkt_ch.word2, pkt_ch.word1, pkt_ch.word0};
      if (pkt_q.size() == 0) begin
        $display("%0t: packet expected none got %h", $time, seen_pkt);
        errors++;
      end else begin
        want_pkt = pkt_q.pop_front();
        for (int k = 0; k < sfpp_pkg::OUT_WORDS; k++) begin
          if (seen_pkt[k] !== want_pkt[k]) begin
            $display("%0t: word%0d expected %h got %h", $time, k, want_pkt[k], seen_pkt[k]);
            errors++;
          end
        end
      end
    end
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      pred_emit = parse_byte(byte_ch.data_byte, pred_pkt);
      if (stim[acc_idx].typed) begin
        if (stim[acc_idx].emit) pkt_q.push_back(stim[acc_idx].words);
      end else if (pred_emit) begin
        pkt_q.push_back(pred_pkt);
      end
      acc_idx++;
    end
  end

  initial begin : finish_ctl
    wait (sending_done);
    // Let the checker log the last accepted byte before looking at the queue.
    @(posedge clk);
    while (pkt_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pkt_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #200000;
    $display("tb failed");
    $finish;
  end

endmodule
